>>> rtl/core/mmhf_pkg.sv
// Package with the shared types and codes of the memory map hole finder.
`timescale 1ns / 1ps
`default_nettype none

package mmhf_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_HOLE    = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_OVERLAP = 2'd2;
  localparam logic [1:0] STATUS_DROPPED = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;      // sorted insert of the incoming entry
    logic shift_left;  // every cell takes the entry of its right neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/memory_map_hole_finder_top.sv
// Top level of the memory map hole finder: cell chain, walk control, result register.
//
// Usage: memory range items (base, size, last) enter on the in_* valid/ready
// channel. Each accepted item is placed into a chain of cells kept sorted by
// base; an item with equal base goes behind the ones already stored. The input
// stays ready while loading. Items beyond MAX_ENTRIES are dropped and flagged.
// The item with entry_last set starts the walk: while the output register is
// free, the chain shifts left one place per cycle and the two head cells form the
// current pair; a map of n entries has at most n-1 pairs before the status item.
// Holes and the status item leave through a single output register on the
// out_* valid/ready channel; while it holds an item the receiver has not
// taken, the walk pauses. The input is not ready during the walk.
// mem_size must be written through cfg_we_i / cfg_wdata_i only while the block
// is idle; the block itself does not enforce this. Reset clears mem_size, the entry
// count and the flags; the block then waits for the first item of a new map.
`timescale 1ns / 1ps
`default_nettype none

module memory_map_hole_finder_top #(
  parameter int MAX_ENTRIES = 32,
  parameter int ADDR_BITS   = 52
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [ADDR_BITS-1:0]   cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [ADDR_BITS-1:0]   entry_base_i,
  input  wire logic [ADDR_BITS-1:0]   entry_size_i,
  input  wire logic                   entry_last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [ADDR_BITS-1:0]        hole_base_o,
  output logic [ADDR_BITS-1:0]        hole_size_o,
  output logic [1:0]                  status_o,
  output logic                        any_hole_o,
  output logic                        last_result_o
);
  import mmhf_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_e               state_q, state_d;
  logic [ADDR_BITS-1:0] mem_size_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic                 ovf_q, ovf_d;
  logic                 err_q, err_d;
  logic                 any_q, any_d;

  logic                 ovalid_q, ovalid_d;
  logic [ADDR_BITS-1:0] obase_q, obase_d;
  logic [ADDR_BITS-1:0] osize_q, osize_d;
  logic [1:0]           ostat_q, ostat_d;
  logic                 oany_q, oany_d;
  logic                 olast_q, olast_d;

  cell_ctrl_t           ctrl;
  logic                 in_acc;
  logic                 has_room;
  logic                 out_free;

  logic [ADDR_BITS-1:0] cbase [MAX_ENTRIES];
  logic [ADDR_BITS-1:0] csize [MAX_ENTRIES];
  logic                 cgt   [MAX_ENTRIES];

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign has_room   = (count_q < CW'(MAX_ENTRIES));
  assign out_free   = !ovalid_q || out_ready_i;

  // Pair evaluation at the head of the chain.
  logic [ADDR_BITS:0]   sum_ext;
  logic [ADDR_BITS-1:0] sum;
  logic [ADDR_BITS-1:0] gap;
  logic                 pair_stop, pair_err, pair_skip;

  assign sum_ext   = {1'b0, cbase[0]} + {1'b0, csize[0]};
  assign sum       = sum_ext[ADDR_BITS-1:0];
  assign pair_stop = cbase[0] > mem_size_q;
  assign pair_err  = (cbase[0] == cbase[1]) || sum_ext[ADDR_BITS] || (sum > cbase[1]);
  assign pair_skip = sum >= mem_size_q;
  assign gap       = (cbase[1] > mem_size_q) ? (mem_size_q - sum) : (cbase[1] - sum);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    ovf_d    = ovf_q;
    err_d    = err_q;
    any_d    = any_q;
    ovalid_d = ovalid_q && !out_ready_i;
    obase_d  = obase_q;
    osize_d  = osize_q;
    ostat_d  = ostat_q;
    oany_d   = oany_q;
    olast_d  = olast_q;
    ctrl     = '{insert: 1'b0, shift_left: 1'b0};
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            ctrl.insert = 1'b1;
            count_d     = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (entry_last_i) begin
            state_d = ST_WALK;
            rem_d   = (count_d >= CW'(2)) ? (count_d - CW'(1)) : '0;
          end
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (rem_q == '0) begin
            ovalid_d = 1'b1;
            obase_d  = '0;
            osize_d  = '0;
            ostat_d  = err_q ? STATUS_OVERLAP : (ovf_q ? STATUS_DROPPED : STATUS_DONE);
            oany_d   = any_q;
            olast_d  = 1'b1;
            state_d  = ST_LOAD;
            count_d  = '0;
            ovf_d    = 1'b0;
            err_d    = 1'b0;
            any_d    = 1'b0;
          end else if (pair_stop) begin
            rem_d = '0;
          end else if (pair_err) begin
            err_d = 1'b1;
            rem_d = '0;
          end else begin
            ctrl.shift_left = 1'b1;
            rem_d           = rem_q - CW'(1);
            if (!pair_skip && (gap != '0)) begin
              ovalid_d = 1'b1;
              obase_d  = sum;
              osize_d  = gap;
              ostat_d  = STATUS_HOLE;
              oany_d   = 1'b0;
              olast_d  = 1'b0;
              any_d    = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                 prev_gt;
    logic [ADDR_BITS-1:0] prev_base, prev_size, next_base, next_size;
    if (i == 0) begin : g_head
      assign prev_gt   = 1'b0;
      assign prev_base = entry_base_i;
      assign prev_size = entry_size_i;
    end else begin : g_body
      assign prev_gt   = cgt[i-1];
      assign prev_base = cbase[i-1];
      assign prev_size = csize[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_base = cbase[i];
      assign next_size = csize[i];
    end else begin : g_mid
      assign next_base = cbase[i+1];
      assign next_size = csize[i+1];
    end
    mmhf_cell #(
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CW'(i) < count_q),
      .new_base_i  (entry_base_i),
      .new_size_i  (entry_size_i),
      .prev_gt_i   (prev_gt),
      .prev_base_i (prev_base),
      .prev_size_i (prev_size),
      .next_base_i (next_base),
      .next_size_i (next_size),
      .gt_o        (cgt[i]),
      .base_o      (cbase[i]),
      .size_o      (csize[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      mem_size_q <= '0;
      count_q    <= '0;
      rem_q      <= '0;
      ovf_q      <= 1'b0;
      err_q      <= 1'b0;
      any_q      <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      ovf_q    <= ovf_d;
      err_q    <= err_d;
      any_q    <= any_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        mem_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obase_q <= obase_d;
    osize_q <= osize_d;
    ostat_q <= ostat_d;
    oany_q  <= oany_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign hole_base_o   = obase_q;
  assign hole_size_o   = osize_q;
  assign status_o      = ostat_q;
  assign any_hole_o    = oany_q;
  assign last_result_o = olast_q;

endmodule

`default_nettype wire

>>> rtl/core/mmhf_cell.sv
// One cell of the sorted entry chain: holds a single (base, size) entry.
`timescale 1ns / 1ps
`default_nettype none

module mmhf_cell #(
  parameter int ADDR_BITS = 52
) (
  input  wire logic                   clk_i,
  input  wire mmhf_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic                   occupied_i,
  input  wire logic [ADDR_BITS-1:0]   new_base_i,
  input  wire logic [ADDR_BITS-1:0]   new_size_i,
  input  wire logic                   prev_gt_i,
  input  wire logic [ADDR_BITS-1:0]   prev_base_i,
  input  wire logic [ADDR_BITS-1:0]   prev_size_i,
  input  wire logic [ADDR_BITS-1:0]   next_base_i,
  input  wire logic [ADDR_BITS-1:0]   next_size_i,
  output logic                        gt_o,
  output logic [ADDR_BITS-1:0]        base_o,
  output logic [ADDR_BITS-1:0]        size_o
);
  import mmhf_pkg::*;

  logic [ADDR_BITS-1:0] base_q, base_d;
  logic [ADDR_BITS-1:0] size_q, size_d;

  // An empty cell counts as greater, so the new entry lands after all
  // stored entries with a base at or below its own.
  assign gt_o = !occupied_i || (base_q > new_base_i);

  always_comb begin
    base_d = base_q;
    size_d = size_q;
    if (ctrl_i.insert) begin
      if (gt_o && !prev_gt_i) begin
        base_d = new_base_i;
        size_d = new_size_i;
      end else if (gt_o && prev_gt_i) begin
        base_d = prev_base_i;
        size_d = prev_size_i;
      end
    end else if (ctrl_i.shift_left) begin
      base_d = next_base_i;
      size_d = next_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    size_q <= size_d;
  end

  assign base_o = base_q;
  assign size_o = size_q;

endmodule

`default_nettype wire

>>> tb/memory_map_hole_finder_checker.sv
// Checker for the memory map hole finder: watches both channels and predicts every hole.
`timescale 1ns / 1ps

module memory_map_hole_finder_checker #(
  parameter int MAX_ENTRIES = 32,
  parameter int ADDR_BITS   = 52
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ADDR_BITS-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ADDR_BITS-1:0] entry_base_i,
  input  logic [ADDR_BITS-1:0] entry_size_i,
  input  logic                 entry_last_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ADDR_BITS-1:0] hole_base_i,
  input  logic [ADDR_BITS-1:0] hole_size_i,
  input  logic [1:0]           status_i,
  input  logic                 any_hole_i,
  input  logic                 last_result_i,
  output int                   fail_count_o,
  output int                   pending_count_o
);
  import mmhf_pkg::*;

  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef struct packed {
    addr_t      base;
    addr_t      size;
    logic [1:0] status;
    logic       any_hole;
    logic       last_result;
  } hole_rec_t;

  addr_t     mem_limit;
  addr_t     range_base [MAX_ENTRIES];
  addr_t     range_size [MAX_ENTRIES];
  int        ranges_held;
  bit        ranges_dropped;
  hole_rec_t expected_holes [$];

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Stable exchange sort by base; it steps back one place after every swap not at the first place.
  task automatic sort_ranges(input int n);
    int    i;
    addr_t tb;
    addr_t ts;
    i = 0;
    while (n > 1 && i < n - 1) begin
      if (range_base[i] > range_base[i+1]) begin
        tb = range_base[i];
        ts = range_size[i];
        range_base[i]   = range_base[i+1];
        range_size[i]   = range_size[i+1];
        range_base[i+1] = tb;
        range_size[i+1] = ts;
        if (i != 0) i--;
      end else begin
        i++;
      end
    end
  endtask

  task automatic predict_holes(input addr_t b, input addr_t s, input logic last);
    int                 n;
    bit                 found;
    bit                 overlap;
    addr_t              cb;
    addr_t              nb;
    addr_t              gap;
    logic [ADDR_BITS:0] span_end;
    hole_rec_t          rec;
    found   = 0;
    overlap = 0;
    if (ranges_held < MAX_ENTRIES) begin
      range_base[ranges_held] = b;
      range_size[ranges_held] = s;
      ranges_held++;
    end else begin
      ranges_dropped = 1;
    end
    if (!last) return;

    n = ranges_held;
    sort_ranges(n);
    for (int i = 0; i < n - 1; i++) begin
      cb = range_base[i];
      nb = range_base[i+1];
      if (cb > mem_limit) break;
      if (cb == nb) begin
        overlap = 1;
        break;
      end
      // The extra top bit catches an end that wraps past the address width.
      span_end = {1'b0, cb} + {1'b0, range_size[i]};
      if (span_end[ADDR_BITS] || span_end[ADDR_BITS-1:0] > nb) begin
        overlap = 1;
        break;
      end
      if (span_end[ADDR_BITS-1:0] >= mem_limit) continue;
      gap = (nb > mem_limit) ? mem_limit - span_end[ADDR_BITS-1:0]
                             : nb - span_end[ADDR_BITS-1:0];
      if (gap != '0) begin
        rec = '{base: span_end[ADDR_BITS-1:0], size: gap, status: STATUS_HOLE,
                any_hole: 1'b0, last_result: 1'b0};
        expected_holes.push_back(rec);
        found = 1;
      end
    end

    rec = '{base: '0, size: '0, status: STATUS_DONE, any_hole: found, last_result: 1'b1};
    if (overlap) rec.status = STATUS_OVERLAP;
    else if (ranges_dropped) rec.status = STATUS_DROPPED;
    expected_holes.push_back(rec);
    ranges_held    = 0;
    ranges_dropped = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hole_rec_t rec;
    if (!rst_ni) begin
      mem_limit      = '0;
      ranges_held    = 0;
      ranges_dropped = 0;
      expected_holes.delete();
      fail_count_o   = 0;
    end else begin
      if (cfg_we_i) mem_limit = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_holes.size() == 0) begin
          $error("result item with nothing expected: base 0x%0h size 0x%0h status %0d",
                 hole_base_i, hole_size_i, status_i);
          fail_count_o++;
        end else begin
          rec = expected_holes.pop_front();
          check_field("hole_base", 64'(rec.base), 64'(hole_base_i));
          check_field("hole_size", 64'(rec.size), 64'(hole_size_i));
          check_field("status", 64'(rec.status), 64'(status_i));
          check_field("any_hole", 64'(rec.any_hole), 64'(any_hole_i));
          check_field("last_result", 64'(rec.last_result), 64'(last_result_i));
        end
      end
      if (in_valid_i && in_ready_i) predict_holes(entry_base_i, entry_size_i, entry_last_i);
    end
    pending_count_o = expected_holes.size();
  end

endmodule

>>> tb/memory_map_hole_finder_top_tb.sv
// Testbench top for the memory map hole finder: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module memory_map_hole_finder_top_tb;
  import mmhf_pkg::*;

  localparam int ADDR_BITS   = 52;
  localparam int MAX_ENTRIES = 32;
  localparam int ITEM_GOAL   = 460;
  localparam int STALL_LIMIT = 4000;
  localparam longint unsigned ADDR_MAX = (64'd1 << ADDR_BITS) - 1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef struct {
    addr_t base;
    addr_t size;
  } range_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  addr_t                cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  addr_t                entry_base;
  addr_t                entry_size;
  logic                 entry_last;
  logic                 out_valid;
  logic                 out_ready;
  addr_t                hole_base;
  addr_t                hole_size;
  logic [1:0]           status;
  logic                 any_hole;
  logic                 last_result;
  int                   fail_count;
  int                   pending_count;
  int                   items_sent;
  int                   quiet_cycles;
  bit                   calm;

  memory_map_hole_finder_top #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ADDR_BITS  (ADDR_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .entry_base_i (entry_base),
    .entry_size_i (entry_size),
    .entry_last_i (entry_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hole_base_o  (hole_base),
    .hole_size_o  (hole_size),
    .status_o     (status),
    .any_hole_o   (any_hole),
    .last_result_o(last_result)
  );

  memory_map_hole_finder_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .entry_base_i   (entry_base),
    .entry_size_i   (entry_size),
    .entry_last_i   (entry_last),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .hole_base_i    (hole_base),
    .hole_size_i    (hole_size),
    .status_i       (status),
    .any_hole_i     (any_hole),
    .last_result_i  (last_result),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  task automatic write_mem_size(input addr_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_entry(input addr_t b, input addr_t s, input logic last);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    entry_base <= b;
    entry_size <= s;
    entry_last <= last;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // Sends one whole map and returns once its status item has been taken.
  task automatic send_map(input range_t ranges[$]);
    foreach (ranges[k]) send_entry(ranges[k].base, ranges[k].size, k == ranges.size() - 1);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic send_random_map(input int map_idx);
    range_t          ranges[$];
    range_t          tmp;
    int              n;
    int              pick;
    int              j;
    int              k;
    longint unsigned lim;
    addr_t           mem_value;
    pick = $urandom_range(0, 99);
    if (map_idx < 2)   n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 8);
    else if (pick < 70) n = $urandom_range(1, 8);
    else if (pick < 90) n = $urandom_range(9, MAX_ENTRIES);
    else               n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 8);

    if ($urandom_range(0, 7) == 0) begin
      // Noise: fully random ranges, mostly overlapping.
      for (j = 0; j < n; j++) ranges.push_back('{rand_addr(), rand_addr()});
    end else begin
      // Well-formed: each range starts in its own slot of width lim; some are then stretched or made to overlap.
      lim = (ADDR_MAX / n) >> $urandom_range(0, 40);
      if (lim < 4) lim = 4;
      for (j = 0; j < n; j++) begin
        tmp.base = addr_t'(j * lim + ({$urandom, $urandom} % (lim / 2)));
        tmp.size = addr_t'({$urandom, $urandom} % (lim / 2 + 1));
        ranges.push_back(tmp);
      end
      for (j = 0; j < n - 1; j++) begin
        if ($urandom_range(0, 4) == 0) ranges[j].size = ranges[j+1].base - ranges[j].base;
      end
      if (n > 1 && (map_idx == 1 || $urandom_range(0, 7) == 0)) begin
        j = $urandom_range(0, n - 2);
        if ($urandom_range(0, 1) == 0) begin
          ranges[j+1].base = ranges[j].base;
        end else begin
          ranges[j].size = ranges[j+1].base - ranges[j].base + addr_t'($urandom_range(1, 4));
        end
      end
    end

    for (j = n - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp       = ranges[j];
      ranges[j] = ranges[k];
      ranges[k] = tmp;
    end

    if (map_idx == 0 || $urandom_range(0, 2) == 0) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 4))
        0: mem_value = '0;
        1: mem_value = addr_t'(ADDR_MAX);
        2: mem_value = rand_addr();
        3: mem_value = ranges[k].base + addr_t'($urandom_range(0, 2));
        default: mem_value = ranges[k].base + ranges[k].size;
      endcase
      write_mem_size(mem_value);
    end
    send_map(ranges);
  endtask

  initial begin
    int map_idx;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    entry_base   = '0;
    entry_size   = '0;
    entry_last   = 1'b0;
    items_sent   = 0;
    calm         = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With memory size at its reset value of zero, every gap starts beyond it.
    send_map('{'{52'h0, 52'h10}, '{52'h20, 52'h0}});

    write_mem_size(addr_t'(ADDR_MAX));
    // A single range walks no pair.
    send_map('{'{addr_t'(ADDR_MAX), addr_t'(ADDR_MAX)}});
    // Out of order, one hole after sorting.
    send_map('{'{52'h1000, 52'h100}, '{52'h0, 52'h10}});
    // Equal bases.
    send_map('{'{52'h5, 52'h1}, '{52'h5, 52'h2}});
    // Overlapping ranges.
    send_map('{'{52'h0, 52'h20}, '{52'h10, 52'h1}});
    // The end of the first range wraps past the address width.
    send_map('{'{addr_t'(ADDR_MAX - 1), 52'h2}, '{addr_t'(ADDR_MAX), 52'h0}});
    // Touching ranges leave an empty gap.
    send_map('{'{52'h0, 52'h10}, '{52'h10, 52'h10}});

    write_mem_size(52'h1000);
    // Hole, hole cut at the memory size, then a base above it stops the walk.
    send_map('{'{52'h2000, 52'h10}, '{52'h0, 52'h100}, '{52'h3000, 52'h1},
               '{52'h800, 52'h100}});
    // Gap starts at the memory size: no hole.
    send_map('{'{52'h0, 52'h1000}, '{52'h1800, 52'h1}});

    map_idx = 0;
    while (items_sent < ITEM_GOAL) begin
      calm = (map_idx >= 20 && map_idx < 30);
      send_random_map(map_idx);
      map_idx++;
    end
    calm = 0;

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_count != 0) $error("%0d result items never arrived", pending_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
